/* rtl/core/jvs_pkg.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// Joystick velocity shaper package
// Shared types and constants of the shaper core.
// -----------------------------------------------------------------------------
package jvs_pkg;

  localparam int unsigned AXIS_W  = 16;
  localparam int unsigned VEL_W   = 24;
  localparam int unsigned SCALE_W = 19;
  localparam int unsigned DZ_W    = 14;
  localparam int unsigned LIM_W   = 18;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 19;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEAD_BAND   = 3'd0,
    CFG_LINEAR_LIM  = 3'd1,
    CFG_ANGULAR_LIM = 3'd2,
    CFG_SCALE_INC   = 3'd3,
    CFG_INIT_SCALE  = 3'd4
  } cfg_idx_e;

  // Item handed from the front part to the back part.
  typedef struct packed {
    logic signed [AXIS_W-1:0] fwd;
    logic signed [AXIS_W-1:0] side;
    logic signed [AXIS_W-1:0] rot;
    logic [SCALE_W-1:0]       scale;
    logic                     serve;
    logic                     stop;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DZ,
    BK_SQRT,
    BK_NORM,
    BK_VEL,
    BK_OUT
  } bk_state_e;

endpackage : jvs_pkg
`default_nettype wire

/* rtl/core/jvs_if.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// Joystick velocity shaper channel interfaces
// Valid/ready channels for samples, commands and configuration writes.
// -----------------------------------------------------------------------------
interface jvs_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] forward_axis;
  logic signed [15:0] strafe_axis;
  logic signed [15:0] rotate_axis;
  logic speed_up_button;
  logic speed_down_button;
  logic stop_button;
  logic serve_button;
  modport source (output valid, forward_axis, strafe_axis, rotate_axis, speed_up_button,
                  speed_down_button, stop_button, serve_button, input ready);
  modport sink (input valid, forward_axis, strafe_axis, rotate_axis, speed_up_button,
                speed_down_button, stop_button, serve_button, output ready);
endinterface

interface jvs_out_if;
  logic valid;
  logic ready;
  logic signed [23:0] vel_forward;
  logic signed [23:0] vel_side;
  logic signed [23:0] yaw_rate;
  logic [18:0] scale_now;
  logic serve_pulse;
  logic stop_pulse;
  modport source (output valid, vel_forward, vel_side, yaw_rate, scale_now, serve_pulse,
                  stop_pulse, input ready);
  modport sink (input valid, vel_forward, vel_side, yaw_rate, scale_now, serve_pulse,
                stop_pulse, output ready);
endinterface

interface jvs_cfg_if;
  logic valid;
  logic ready;
  logic [2:0]  index;
  logic [18:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/core/jvs_front.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// Joystick velocity shaper front
// Accepts samples, detects button edges and updates the speed scale.
// -----------------------------------------------------------------------------
module jvs_front #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  jvs_in_if.sink                      in_if,
  input  wire logic                   scale_load_i,
  input  wire logic [18:0]            init_scale_i,
  input  wire logic [18:0]            scale_inc_i,
  output jvs_pkg::job_t               job_o,
  output logic                        job_valid_o,
  input  wire logic                   job_ready_i
);
  import jvs_pkg::*;

  localparam logic [SCALE_W:0] ScaleMaxW = ((20 << FRAC_BITS) > 524287) ? 20'd524287
                                           : (SCALE_W+1)'(20 << FRAC_BITS);
  localparam logic [SCALE_W-1:0] ScaleMax = ScaleMaxW[SCALE_W-1:0];
  localparam logic [SCALE_W-1:0] OneScale = SCALE_W'(64'd1 << FRAC_BITS);

  logic [SCALE_W-1:0] scale_q, scale_d, up_val;
  logic [3:0]         prior_q, btn, rise;
  logic [SCALE_W:0]   sum;
  logic               accept;

  assign in_if.ready = job_ready_i;
  assign job_valid_o = in_if.valid;
  assign accept      = in_if.valid && job_ready_i;

  assign btn  = {in_if.serve_button, in_if.stop_button, in_if.speed_down_button,
                 in_if.speed_up_button};
  assign rise = btn & ~prior_q;

  always_comb begin
    sum    = {1'b0, scale_q} + {1'b0, scale_inc_i};
    up_val = scale_q;
    if (rise[0]) begin
      up_val = (sum > {1'b0, ScaleMax}) ? ScaleMax : sum[SCALE_W-1:0];
    end
    scale_d = up_val;
    if (rise[1]) begin
      scale_d = (up_val > scale_inc_i) ? up_val - scale_inc_i : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= (OneScale > ScaleMax) ? ScaleMax : OneScale;
      prior_q <= '0;
    end else if (scale_load_i) begin
      scale_q <= (init_scale_i > ScaleMax) ? ScaleMax : init_scale_i;
    end else if (accept) begin
      scale_q <= scale_d;
      prior_q <= btn;
    end
  end

  always_comb begin
    job_o.fwd   = in_if.forward_axis;
    job_o.side  = in_if.strafe_axis;
    job_o.rot   = in_if.rotate_axis;
    job_o.scale = scale_d;
    job_o.serve = rise[3];
    job_o.stop  = rise[2];
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    scale_q <= ScaleMax) else $error("scale above limit");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !scale_load_i |=> prior_q == $past(btn)) else $error("button levels lost");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rise & prior_q) == 4'd0) else $error("edge on held button");
endmodule
`default_nettype wire

/* rtl/core/jvs_queue.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// Joystick velocity shaper queue
// Two-entry queue between front and back.
// -----------------------------------------------------------------------------
module jvs_queue (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  jvs_pkg::job_t wr_data_i,
  input  wire logic    wr_valid_i,
  output logic         wr_ready_o,
  output jvs_pkg::job_t rd_data_o,
  output logic         rd_valid_o,
  input  wire logic    rd_ready_i
);
  import jvs_pkg::*;

  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(wr) - 2'(rd);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue overflow");
endmodule
`default_nettype wire

/* rtl/core/jvs_back.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// Joystick velocity shaper back
// Deadzone rescale, radial clamp and velocity products on shared units.
// -----------------------------------------------------------------------------
module jvs_back #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  jvs_pkg::job_t     job_i,
  input  wire logic         job_valid_i,
  output logic              job_ready_o,
  input  wire logic [13:0]  dead_band_i,
  input  wire logic [17:0]  lin_lim_i,
  input  wire logic [17:0]  ang_lim_i,
  jvs_out_if.source         out_if
);
  import jvs_pkg::*;

  localparam int unsigned MW = FRAC_BITS + 2;          // magnitude width (holds ONE)
  localparam int unsigned QW = 2 * MW + 2;             // dividend / square width
  localparam int unsigned DW = MW + FRAC_BITS;         // divider iterations
  localparam int unsigned SW = MW + 1;                 // root width
  localparam int unsigned RI = QW / 2;                 // root iterations
  localparam logic [MW-1:0] One = MW'(1) << FRAC_BITS;
  localparam logic [MW-1:0] DzMax = MW'((99 * (1 << FRAC_BITS)) / 100);
  localparam logic [VEL_W-1:0] VelMax = ((64'd320 << FRAC_BITS) > 64'd8388607) ? 24'h7FFFFF
                                        : VEL_W'(64'd320 << FRAC_BITS);
  localparam int unsigned PW = MW + LIM_W + SCALE_W;

  bk_state_e st_q, st_d;
  logic [MW-1:0] mag_q [3];
  logic [2:0]    neg_q;
  job_t          job_q;
  logic [1:0]    ax_q;
  logic [5:0]    it_q;
  logic [QW-1:0] rem_q, quo_q, den_q;
  logic [SW-1:0] root_q;
  logic [MW-1:0] dz;
  logic [VEL_W-1:0] vel_q [3];
  logic [PW-1:0] prod_q;
  logic          pstage_q;

  function automatic logic [MW-1:0] sat_mag(input logic signed [AXIS_W-1:0] v);
    logic [AXIS_W:0] m;
    m = v[AXIS_W-1] ? (AXIS_W+1)'(-$signed({v[AXIS_W-1], v})) : {1'b0, v};
    sat_mag = (QW'(m) > QW'(One)) ? One : MW'(m);
  endfunction

  assign dz = (QW'(dead_band_i) > QW'(DzMax)) ? DzMax : MW'(dead_band_i);
  assign job_ready_o = st_q == BK_IDLE;

  // restoring divider step and root step
  logic [QW-1:0] trial;
  logic [QW+1:0] rtrial, rrem;
  assign trial  = {rem_q[QW-2:0], quo_q[QW-1]};
  assign rrem   = {rem_q, quo_q[QW-1:QW-2]};
  assign rtrial = {(QW+2-SW-2)'(0), root_q, 2'b01};

  logic [QW-1:0] fsq, ssq;
  assign fsq = QW'(mag_q[0]) * QW'(mag_q[0]);
  assign ssq = QW'(mag_q[1]) * QW'(mag_q[1]);

  logic [LIM_W-1:0] lim;
  assign lim = (ax_q == 2'd2) ? ang_lim_i : lin_lim_i;

  // second product step: multiply by scale (registered between multiplies)
  logic [PW-1:0] prod2;
  assign prod2 = PW'(prod_q[MW+LIM_W-1:0]) * PW'(job_q.scale);
  logic [PW-1:0] p_sh;
  assign p_sh = prod2 >> (2 * FRAC_BITS);

  always_comb begin
    st_d = st_q;
    case (st_q)
      BK_IDLE: if (job_valid_i) st_d = BK_DZ;
      BK_DZ:   if (ax_q == 2'd2 && it_q == 6'(DW + 1)) st_d = BK_SQRT;
      BK_SQRT: if (it_q == 6'(RI + 1)) st_d = (rem_q == '1) ? BK_VEL : BK_NORM;
      BK_NORM: if (ax_q == 2'd1 && it_q == 6'(DW + 1)) st_d = BK_VEL;
      BK_VEL:  if (ax_q == 2'd2 && pstage_q) st_d = BK_OUT;
      BK_OUT:  if (out_if.ready) st_d = BK_IDLE;
      default: st_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= BK_IDLE;
    else st_q <= st_d;
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      BK_IDLE: begin
        job_q <= job_i;
        mag_q[0] <= sat_mag(job_i.fwd);
        mag_q[1] <= sat_mag(job_i.side);
        mag_q[2] <= sat_mag(job_i.rot);
        neg_q <= {job_i.rot[AXIS_W-1], job_i.side[AXIS_W-1], job_i.fwd[AXIS_W-1]};
        ax_q <= '0; it_q <= '0;
      end
      BK_DZ: begin
        if (it_q == 6'd0) begin
          rem_q <= '0;
          if (mag_q[ax_q] < dz) begin
            quo_q <= '0; den_q <= '1;   // forces zero quotient
          end else begin
            quo_q <= QW'(mag_q[ax_q] - dz) << (QW - DW + FRAC_BITS);
            den_q <= QW'(One - dz);
          end
          it_q <= 6'd1;
        end else if (it_q == 6'(DW + 1)) begin
          mag_q[ax_q] <= MW'(quo_q);
          it_q <= '0;
          ax_q <= (ax_q == 2'd2) ? 2'd0 : ax_q + 2'd1;
        end else begin
          if (trial >= den_q) begin rem_q <= trial - den_q; quo_q <= {quo_q[QW-2:0], 1'b1}; end
          else begin rem_q <= trial; quo_q <= {quo_q[QW-2:0], 1'b0}; end
          it_q <= it_q + 6'd1;
        end
      end
      BK_SQRT: begin
        if (it_q == 6'd0) begin
          quo_q <= fsq + ssq; root_q <= '0; it_q <= 6'd1;
          // an all-ones remainder marks a vector that needs no normalizing
          rem_q <= (fsq + ssq <= QW'(One) * QW'(One)) ? '1 : '0;
        end else if (it_q == 6'(RI + 1)) begin
          it_q <= '0; ax_q <= '0;
        end else begin
          if (rem_q != '1) begin
            if (rrem >= rtrial) begin
              rem_q <= QW'(rrem - rtrial); root_q <= {root_q[SW-2:0], 1'b1};
            end else begin
              rem_q <= QW'(rrem); root_q <= {root_q[SW-2:0], 1'b0};
            end
            quo_q <= quo_q << 2;
          end
          it_q <= it_q + 6'd1;
        end
      end
      BK_NORM: begin
        if (it_q == 6'd0) begin
          quo_q <= QW'(mag_q[ax_q]) << (QW - DW + FRAC_BITS);
          rem_q <= '0; den_q <= QW'(root_q); it_q <= 6'd1;
        end else if (it_q == 6'(DW + 1)) begin
          mag_q[ax_q] <= MW'(quo_q);
          it_q <= '0; ax_q <= (ax_q == 2'd1) ? 2'd0 : ax_q + 2'd1;
        end else begin
          if (trial >= den_q) begin rem_q <= trial - den_q; quo_q <= {quo_q[QW-2:0], 1'b1}; end
          else begin rem_q <= trial; quo_q <= {quo_q[QW-2:0], 1'b0}; end
          it_q <= it_q + 6'd1;
        end
      end
      BK_VEL: begin
        if (!pstage_q) begin
          prod_q <= PW'(PW'(mag_q[ax_q]) * PW'(lim));
        end else begin
          if (p_sh > PW'(VelMax)) vel_q[ax_q] <= neg_q[ax_q] ? -VelMax : VelMax;
          else vel_q[ax_q] <= neg_q[ax_q] ? -VEL_W'(p_sh) : VEL_W'(p_sh);
          ax_q <= ax_q + 2'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pstage_q <= 1'b0;
    else if (st_q == BK_VEL) pstage_q <= ~pstage_q;
    else pstage_q <= 1'b0;
  end

  assign out_if.valid       = st_q == BK_OUT;
  assign out_if.vel_forward = vel_q[0];
  assign out_if.vel_side    = vel_q[1];
  assign out_if.yaw_rate    = vel_q[2];
  assign out_if.scale_now   = job_q.scale;
  assign out_if.serve_pulse = job_q.serve;
  assign out_if.stop_pulse  = job_q.stop;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid) else $error("result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_ready_o |-> !out_if.valid) else $error("accepted while holding result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == BK_OUT |-> ax_q == 2'd3 || ax_q == 2'd0) else $error("lane count off");
endmodule
`default_nettype wire

/* rtl/core/joystick_velocity_shaper_unit.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// Joystick velocity shaper unit
// Turns stick samples into saturated velocity commands with a speed scale.
// -----------------------------------------------------------------------------
// Usage:
//  - in_if carries one sample per transfer: three Q1.14 axes and four buttons.
//  - out_if returns one result per sample: three velocities, the scale after
//    the sample, and serve/stop press pulses.
//  - cfg_if writes registers 0..4 (dead band, linear limit, angular limit,
//    scale step, initial scale); write only while no sample is in flight.
//  - The front stage takes a sample whenever the queue has room, handles button
//    edges and the speed scale, and pushes it into a two-entry queue.
//  - The back stage works one sample at a time: three serial deadzone
//    divisions, a serial square root and, when the stick vector is longer
//    than 1.0, two serial normalizing divisions, then a multiply by the
//    limit and a multiply by the scale for each axis.
//  - The back takes a new sample only once the last result has transferred;
//    the deadzone and normalizing divisions share one serial divider.
//  - A stalled receiver holds the result; the queue keeps accepting up to
//    two more samples.
//  - Reset loads the default registers, the scale to 1.0 and clears the
//    button history.
// -----------------------------------------------------------------------------
module joystick_velocity_shaper_unit #(
  parameter int unsigned FRAC_BITS = 14
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  jvs_in_if.sink   in_if,
  jvs_out_if.source out_if,
  jvs_cfg_if.sink  cfg_if
);
  import jvs_pkg::*;

  localparam logic [LIM_W-1:0]   LimReset = LIM_W'(64'd1 << FRAC_BITS);
  localparam logic [SCALE_W-1:0] IncReset = SCALE_W'((64'd1 << FRAC_BITS) / 64'd10);

  logic [13:0] dz_q;
  logic [17:0] lin_q, ang_q;
  logic [18:0] inc_q;
  logic        load;
  job_t        fj, bj;
  logic        fv, fr, bv, br;

  assign cfg_if.ready = 1'b1;
  assign load = cfg_if.valid && cfg_if.index == CFG_INIT_SCALE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_q <= '0; lin_q <= LimReset; ang_q <= LimReset;
      inc_q <= IncReset;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        CFG_DEAD_BAND:   dz_q   <= cfg_if.data[13:0];
        CFG_LINEAR_LIM:  lin_q  <= cfg_if.data[17:0];
        CFG_ANGULAR_LIM: ang_q  <= cfg_if.data[17:0];
        CFG_SCALE_INC:   inc_q  <= cfg_if.data;
        default: ;
      endcase
    end
  end

  jvs_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i, .rst_ni, .in_if, .scale_load_i(load), .init_scale_i(cfg_if.data),
    .scale_inc_i(inc_q), .job_o(fj), .job_valid_o(fv), .job_ready_i(fr)
  );

  jvs_queue u_queue (
    .clk_i, .rst_ni, .wr_data_i(fj), .wr_valid_i(fv), .wr_ready_o(fr),
    .rd_data_o(bj), .rd_valid_o(bv), .rd_ready_i(br)
  );

  jvs_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i, .rst_ni, .job_i(bj), .job_valid_i(bv), .job_ready_o(br),
    .dead_band_i(dz_q), .lin_lim_i(lin_q), .ang_lim_i(ang_q), .out_if
  );
endmodule
`default_nettype wire

/* tb/jvs_shaper_checker.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Joystick velocity shaper checker
// Watches the sample, result and config channels. Keeps its own copy of the
// registers, scale and button history, predicts each result and compares it.
// -----------------------------------------------------------------------------
module jvs_shaper_checker (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  jvs_in_if.sink    in_mon,
  jvs_out_if.sink   out_mon,
  jvs_cfg_if.sink   cfg_mon,
  output int unsigned fail_count,
  output int unsigned pending_count
);
  import jvs_pkg::*;

  localparam int unsigned FB = 14;
  localparam longint unsigned ONE_Q = 64'd1 << FB;
  localparam longint unsigned SCALE_CAP = 64'd20 << FB;
  localparam longint unsigned VEL_CAP = 64'd320 << FB;

  typedef struct packed {
    logic [VEL_W-1:0]   fwd;
    logic [VEL_W-1:0]   side;
    logic [VEL_W-1:0]   yaw;
    logic [SCALE_W-1:0] scale;
    logic               serve;
    logic               stop;
  } velocity_cmd_t;

  velocity_cmd_t cmd_queue[$];

  logic [DZ_W-1:0]    dead_band_q;
  logic [LIM_W-1:0]   lin_lim_q;
  logic [LIM_W-1:0]   ang_lim_q;
  logic [SCALE_W-1:0] step_q;
  logic [SCALE_W-1:0] scale_q;
  logic [3:0]         btn_q;

  assign pending_count = cmd_queue.size();

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned axis_mag(logic signed [15:0] v);
    longint signed a;
    a = v;
    if (a < 0) a = -a;
    return (a > ONE_Q) ? ONE_Q : a;
  endfunction

  function automatic longint unsigned shape_dz(longint unsigned m);
    longint unsigned dz, dz_cap;
    dz = dead_band_q;
    dz_cap = (99 * ONE_Q) / 100;
    if (dz > dz_cap) dz = dz_cap;
    if (m < dz) return 0;
    return ((m - dz) * ONE_Q) / (ONE_Q - dz);
  endfunction

  function automatic logic [VEL_W-1:0] vel_of(longint unsigned m, logic neg,
                                              longint unsigned lim);
    longint unsigned p;
    p = (m * lim * scale_q) >> (2 * FB);
    if (p > VEL_CAP) p = VEL_CAP;
    return neg ? VEL_W'(-p) : VEL_W'(p);
  endfunction

  // Advance the kept state by one sample and return the command it yields.
  function automatic velocity_cmd_t shape_sample(logic signed [15:0] f,
      logic signed [15:0] s, logic signed [15:0] r, logic [3:0] btn);
    velocity_cmd_t c;
    logic [3:0] rise;
    longint unsigned fm, sm, rm, sum, n, t;
    rise = btn & ~btn_q;
    if (rise[0]) begin
      t = scale_q + step_q;
      scale_q = SCALE_W'((t > SCALE_CAP) ? SCALE_CAP : t);
    end
    if (rise[1]) scale_q = (scale_q > step_q) ? scale_q - step_q : '0;
    btn_q = btn;
    fm = shape_dz(axis_mag(f));
    sm = shape_dz(axis_mag(s));
    rm = shape_dz(axis_mag(r));
    sum = fm * fm + sm * sm;
    if (sum > ONE_Q * ONE_Q) begin
      n = int_sqrt(sum);
      fm = (fm * ONE_Q) / n;
      sm = (sm * ONE_Q) / n;
    end
    c.fwd   = vel_of(fm, f < 0, lin_lim_q);
    c.side  = vel_of(sm, s < 0, lin_lim_q);
    c.yaw   = vel_of(rm, r < 0, ang_lim_q);
    c.scale = scale_q;
    c.serve = rise[3];
    c.stop  = rise[2];
    return c;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    velocity_cmd_t want;
    if (!rst_ni) begin
      dead_band_q = '0;
      lin_lim_q   = LIM_W'(ONE_Q);
      ang_lim_q   = LIM_W'(ONE_Q);
      step_q      = SCALE_W'(ONE_Q / 10);
      scale_q     = SCALE_W'(ONE_Q);
      btn_q       = '0;
      fail_count  = 0;
      cmd_queue.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_idx_e'(cfg_mon.index))
          CFG_DEAD_BAND:   dead_band_q = cfg_mon.data[DZ_W-1:0];
          CFG_LINEAR_LIM:  lin_lim_q = cfg_mon.data[LIM_W-1:0];
          CFG_ANGULAR_LIM: ang_lim_q = cfg_mon.data[LIM_W-1:0];
          CFG_SCALE_INC:   step_q = cfg_mon.data;
          CFG_INIT_SCALE:  scale_q = (cfg_mon.data > SCALE_CAP) ? SCALE_W'(SCALE_CAP)
                                                                : cfg_mon.data;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        cmd_queue.push_back(shape_sample(in_mon.forward_axis, in_mon.strafe_axis,
            in_mon.rotate_axis, {in_mon.serve_button, in_mon.stop_button,
            in_mon.speed_down_button, in_mon.speed_up_button}));
      if (out_mon.valid && out_mon.ready) begin
        if (cmd_queue.size() == 0) begin
          report_mismatch("unexpected result", 0, 0);
        end else begin
          want = cmd_queue.pop_front();
          if (out_mon.vel_forward !== want.fwd)
            report_mismatch("vel_forward", out_mon.vel_forward, $signed(want.fwd));
          if (out_mon.vel_side !== want.side)
            report_mismatch("vel_side", out_mon.vel_side, $signed(want.side));
          if (out_mon.yaw_rate !== want.yaw)
            report_mismatch("yaw_rate", out_mon.yaw_rate, $signed(want.yaw));
          if (out_mon.scale_now !== want.scale)
            report_mismatch("scale_now", out_mon.scale_now, want.scale);
          if (out_mon.serve_pulse !== want.serve)
            report_mismatch("serve_pulse", out_mon.serve_pulse, want.serve);
          if (out_mon.stop_pulse !== want.stop)
            report_mismatch("stop_pulse", out_mon.stop_pulse, want.stop);
        end
      end
    end
  end

endmodule

/* tb/joystick_velocity_shaper_unit_tb.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Joystick velocity shaper unit testbench
// Drives directed and random stick samples under several register settings
// with random idling on both channels; a checker compares every result.
// -----------------------------------------------------------------------------
module joystick_velocity_shaper_unit_tb;
  import jvs_pkg::*;

  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned RANDOM_SAMPLES = 1830;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  jvs_in_if  in_if ();
  jvs_out_if out_if ();
  jvs_cfg_if cfg_if ();

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned quiet_cycles;

  joystick_velocity_shaper_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  jvs_shaper_checker checker_inst (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_mon        (in_if),
    .out_mon       (out_if),
    .cfg_mon       (cfg_if),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver: drop ready at random according to the current idle share.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: count cycles with no transfer on any channel.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Send one sample; idle at random first, then hold until the transfer.
  // Valid stays high afterwards so samples can follow back to back.
  task automatic send_sample(logic signed [15:0] f, logic signed [15:0] s,
                             logic signed [15:0] r, logic [3:0] btn);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid             <= 1'b1;
    in_if.forward_axis      <= f;
    in_if.strafe_axis       <= s;
    in_if.rotate_axis       <= r;
    in_if.speed_up_button   <= btn[0];
    in_if.speed_down_button <= btn[1];
    in_if.stop_button       <= btn[2];
    in_if.serve_button      <= btn[3];
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // Wait until all results are back and the back stage has gone quiet.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (pending_count != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [18:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
  endtask

  function automatic logic signed [15:0] rand_axis();
    case ($urandom_range(9))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'($urandom);
      3: return 16'($urandom_range(400)) - 16'sd200;
      default: return 16'($urandom_range(32768)) - 16'sd16384;
    endcase
  endfunction

  task automatic random_burst(int unsigned count);
    logic [3:0] btn;
    btn = '0;
    repeat (count) begin
      // Buttons mostly hold their level so edges stay meaningful.
      if ($urandom_range(3) == 0) btn = 4'($urandom);
      send_sample(rand_axis(), rand_axis(), rand_axis(), btn);
    end
  endtask

  task automatic load_setting(logic [18:0] dz, logic [18:0] lin, logic [18:0] ang,
                              logic [18:0] inc, logic [18:0] init);
    drain_results();
    write_reg(CFG_DEAD_BAND, dz);
    write_reg(CFG_LINEAR_LIM, lin);
    write_reg(CFG_ANGULAR_LIM, ang);
    write_reg(CFG_SCALE_INC, inc);
    write_reg(CFG_INIT_SCALE, init);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    in_if.valid <= 1'b0;
    in_if.forward_axis <= '0;
    in_if.strafe_axis <= '0;
    in_if.rotate_axis <= '0;
    in_if.speed_up_button <= 1'b0;
    in_if.speed_down_button <= 1'b0;
    in_if.stop_button <= 1'b0;
    in_if.serve_button <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= CFG_DEAD_BAND;
    cfg_if.data <= '0;
    quiet_cycles = 0;
    send_idle_pct = 32;
    recv_idle_pct = 58;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, out-of-range axes, normalization, every button edge.
    send_sample(16'sd0, 16'sd0, 16'sd0, 4'b0000);
    send_sample(16'sd16384, 16'sd16384, -16'sd16384, 4'b0001);
    send_sample(-16'sd32768, 16'sd32767, 16'sd32767, 4'b0001);
    send_sample(16'sd12000, -16'sd12000, 16'sd1, 4'b0010);
    send_sample(-16'sd1, 16'sd16384, -16'sd1, 4'b0011);
    send_sample(16'sd8000, 16'sd100, 16'sd0, 4'b0100);
    send_sample(16'sd0, 16'sd0, 16'sd0, 4'b1100);
    send_sample(16'sd0, 16'sd0, 16'sd0, 4'b1111);
    send_sample(16'sd0, 16'sd0, 16'sd0, 4'b0000);
    send_sample(16'sd0, 16'sd0, 16'sd0, 4'b1111);
    // Saturate the scale upward, then to zero.
    load_setting(19'd16220, 19'd262143, 19'd262143, 19'd327680, 19'd524287);
    send_sample(16'sd16384, 16'sd16384, 16'sd16384, 4'b0001);
    send_sample(16'sd16300, -16'sd16384, -16'sd16220, 4'b0000);
    send_sample(16'sd200, -16'sd16383, 16'sd16219, 4'b0010);
    send_sample(16'sd16384, 16'sd0, 16'sd16384, 4'b0000);
    load_setting(19'd16383, 19'd0, 19'd0, 19'd0, 19'd0);
    send_sample(16'sd16384, -16'sd16384, 16'sd16384, 4'b0011);
    send_sample(16'sd16383, 16'sd16384, -16'sd16384, 4'b0000);

    load_setting(19'd0, 19'd16384, 19'd16384, 19'd1638, 19'd16384);
    random_burst(RANDOM_SAMPLES / 4);
    send_idle_pct = 58;
    recv_idle_pct = 32;
    load_setting(19'($urandom_range(16220)), 19'($urandom), 19'($urandom),
                 19'($urandom_range(40000)), 19'($urandom_range(327680)));
    random_burst(RANDOM_SAMPLES / 4);
    load_setting(19'd16220, 19'd262143, 19'd262143, 19'd327680, 19'd327680);
    random_burst(RANDOM_SAMPLES / 8);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_setting(19'd4000, 19'd100000, 19'd5000, 19'd3000, 19'd200000);
    random_burst(RANDOM_SAMPLES / 4);
    load_setting(19'd0, 19'd262143, 19'd1, 19'd8000, 19'd524287);
    random_burst(RANDOM_SAMPLES / 8);

    drain_results();
    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
